### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock, with or without an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HRS_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rst_s)) prop) else $error(msg);

// Checked at every edge, reset included.
`define HRS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### design/hrs_pkg.sv
// ---------------------------------------------------------------------------
// Heating relay supervisor package
// Types, codes, reset values and helpers shared by the supervisor files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrs_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int CFG_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int MS_W = 26;
    localparam int MS_PER_S = 1000;

    typedef enum logic [1:0] {
        ACT_EVALUATE = 2'd0,
        ACT_BUTTON = 2'd1,
        ACT_LINK = 2'd2,
        ACT_EMERGENCY = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        MODE_OFF = 4'b0001,
        MODE_ACTIVE = 4'b0010,
        MODE_MAN_ON = 4'b0100,
        MODE_MAN_OFF = 4'b1000
    } mode_t;

    localparam logic [1:0] MODE_CODE_OFF = 2'd0;
    localparam logic [1:0] MODE_CODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_CODE_MAN_ON = 2'd2;
    localparam logic [1:0] MODE_CODE_MAN_OFF = 2'd3;

    localparam logic [3:0] REASON_NONE = 4'd0;
    localparam logic [3:0] REASON_CMD_ON = 4'd1;
    localparam logic [3:0] REASON_CMD_OFF = 4'd2;
    localparam logic [3:0] REASON_POWER = 4'd3;
    localparam logic [3:0] REASON_BATTERY = 4'd4;
    localparam logic [3:0] REASON_PV = 4'd5;
    localparam logic [3:0] REASON_SUNSET = 4'd6;
    localparam logic [3:0] REASON_SAFETY = 4'd7;
    localparam logic [3:0] REASON_BUTTON = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POWER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DISCHARGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PV_VOLTAGE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_ON = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_OFF = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_LIMIT = 3'd6;

    localparam logic [CFG_W-1:0] MAX_POWER_RST = 16'd5000;
    localparam logic [CFG_W-1:0] MAX_DISCHARGE_RST = 16'd50;
    localparam logic [CFG_W-1:0] MIN_PV_VOLTAGE_RST = 16'd100;
    localparam logic [CFG_W-1:0] LINK_TIMEOUT_S_RST = 16'd300;
    localparam logic [CFG_W-1:0] HOLD_ON_S_RST = 16'd60;
    localparam logic [CFG_W-1:0] HOLD_OFF_S_RST = 16'd60;
    localparam logic [CFG_W-1:0] MANUAL_LIMIT_S_RST = 16'd3600;

    // Seconds to milliseconds; the product of a 16-bit value and 1000 fits 26 bits.
    function automatic logic [MS_W-1:0] to_ms(input logic [CFG_W-1:0] secs);
        logic [MS_W-1:0] wide;
        wide = {{(MS_W - CFG_W){1'b0}}, secs};
        return wide * MS_W'(MS_PER_S);
    endfunction

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_OFF: code = MODE_CODE_OFF;
            MODE_ACTIVE: code = MODE_CODE_ACTIVE;
            MODE_MAN_ON: code = MODE_CODE_MAN_ON;
            MODE_MAN_OFF: code = MODE_CODE_MAN_OFF;
            default: code = MODE_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

### design/heating_relay_supervisor_core.sv
// ---------------------------------------------------------------------------
// Heating relay supervisor core
// Four-mode relay supervisor with link watchdog, overrides, hold times and a
// manual override timer, one result per transfer.
// ---------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  item     | item_valid / item_stall    | action, now_ms, heating_enabled,
//           |                            | inverter_valid, apparent_power,
//           |                            | discharge_current, pv_voltage,
//           |                            | sunset_active
//  result   | result_valid / result_stall| relay_on, reason, mode, safety_active
//  config   | cfg_we                     | cfg_index, cfg_data
//
// A transfer is registered in the input stage, evaluated there and its result
// is registered in the output stage. One item is taken every cycle unless a
// stalled result holds it; the state update is a single pass of compares.
// Reset brings the configuration, state and valid registers to their reset
// values at once; the data registers of both stages have no reset.
// A stalled result holds the pipeline, and item_stall rises only then.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heating_relay_supervisor_core #(
    parameter int TIME_BITS = hrs_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hrs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       action,
    input  logic [31:0]                      now_ms,
    input  logic                             heating_enabled,
    input  logic                             inverter_valid,
    input  logic [15:0]                      apparent_power,
    input  logic [15:0]                      discharge_current,
    input  logic [15:0]                      pv_voltage,
    input  logic                             sunset_active,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             relay_on,
    output logic [3:0]                       reason,
    output logic [1:0]                       mode,
    output logic                             safety_active
);

    localparam int MS_W = hrs_pkg::MS_W;
    localparam int CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    logic [hrs_pkg::CFG_W-1:0] max_power_reg;
    logic [hrs_pkg::CFG_W-1:0] max_discharge_reg;
    logic [hrs_pkg::CFG_W-1:0] min_pv_reg;
    logic [MS_W-1:0] link_timeout_ms_reg;
    logic [MS_W-1:0] hold_on_ms_reg;
    logic [MS_W-1:0] hold_off_ms_reg;
    logic [MS_W-1:0] manual_limit_ms_reg;

    logic                 s1_valid_reg;
    hrs_pkg::action_t     s1_action_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 s1_enabled_reg;
    logic                 s1_inv_valid_reg;
    logic [15:0]          s1_power_reg;
    logic [15:0]          s1_discharge_reg;
    logic [15:0]          s1_pv_reg;
    logic                 s1_sunset_reg;

    hrs_pkg::mode_t       mode_reg, mode_next;
    logic                 relay_reg, relay_next;
    logic [3:0]           reason_reg, reason_next;
    logic                 safety_reg, safety_next;
    logic [TIME_BITS-1:0] last_switch_reg, last_switch_next;
    logic [TIME_BITS-1:0] manual_start_reg, manual_start_next;
    logic                 saved_auto_reg, saved_auto_next;
    logic [TIME_BITS-1:0] last_link_reg, last_link_next;

    logic       out_valid_reg;
    logic       out_relay_reg;
    logic [3:0] out_reason_reg;
    logic [1:0] out_mode_reg;
    logic       out_safety_reg;

    logic s1_fire;
    logic in_fire;

    logic [TIME_BITS+31:0] now_wide;
    logic [TIME_BITS-1:0]  since_link, since_switch, since_manual;
    logic [TIME_BITS+MS_W-1:0] since_link_w, since_switch_w, since_manual_w;
    logic [TIME_BITS+MS_W-1:0] link_ms_w, hold_ms_w, manual_ms_w;
    logic [MS_W-1:0]       hold_need;
    logic                  link_expired, hold_done, manual_over;
    logic [3:0]            cause;
    logic                  ovr;
    hrs_pkg::mode_t        saved_mode;

    assign s1_fire = s1_valid_reg && !(out_valid_reg && result_stall);
    assign item_stall = s1_valid_reg && !s1_fire;
    assign in_fire = item_valid && !item_stall;
    assign now_wide = {{TIME_BITS{1'b0}}, now_ms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_power_reg <= hrs_pkg::MAX_POWER_RST;
            max_discharge_reg <= hrs_pkg::MAX_DISCHARGE_RST;
            min_pv_reg <= hrs_pkg::MIN_PV_VOLTAGE_RST;
            link_timeout_ms_reg <= hrs_pkg::to_ms(hrs_pkg::LINK_TIMEOUT_S_RST);
            hold_on_ms_reg <= hrs_pkg::to_ms(hrs_pkg::HOLD_ON_S_RST);
            hold_off_ms_reg <= hrs_pkg::to_ms(hrs_pkg::HOLD_OFF_S_RST);
            manual_limit_ms_reg <= hrs_pkg::to_ms(hrs_pkg::MANUAL_LIMIT_S_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hrs_pkg::CFG_MAX_POWER: max_power_reg <= cfg_data;
                hrs_pkg::CFG_MAX_DISCHARGE: max_discharge_reg <= cfg_data;
                hrs_pkg::CFG_MIN_PV_VOLTAGE: min_pv_reg <= cfg_data;
                hrs_pkg::CFG_LINK_TIMEOUT: link_timeout_ms_reg <= hrs_pkg::to_ms(cfg_data);
                hrs_pkg::CFG_HOLD_ON: hold_on_ms_reg <= hrs_pkg::to_ms(cfg_data);
                hrs_pkg::CFG_HOLD_OFF: hold_off_ms_reg <= hrs_pkg::to_ms(cfg_data);
                hrs_pkg::CFG_MANUAL_LIMIT: manual_limit_ms_reg <= hrs_pkg::to_ms(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire || s1_fire)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= hrs_pkg::action_t'(action);
            s1_now_reg <= now_wide[TIME_BITS-1:0];
            s1_enabled_reg <= heating_enabled;
            s1_inv_valid_reg <= inverter_valid;
            s1_power_reg <= apparent_power;
            s1_discharge_reg <= discharge_current;
            s1_pv_reg <= pv_voltage;
            s1_sunset_reg <= sunset_active;
        end
    end

    assign since_link = s1_now_reg - last_link_reg;
    assign since_switch = s1_now_reg - last_switch_reg;
    assign since_manual = s1_now_reg - manual_start_reg;
    assign hold_need = relay_reg ? hold_on_ms_reg : hold_off_ms_reg;

    assign since_link_w = {{MS_W{1'b0}}, since_link};
    assign since_switch_w = {{MS_W{1'b0}}, since_switch};
    assign since_manual_w = {{MS_W{1'b0}}, since_manual};
    assign link_ms_w = {{TIME_BITS{1'b0}}, link_timeout_ms_reg};
    assign hold_ms_w = {{TIME_BITS{1'b0}}, hold_need};
    assign manual_ms_w = {{TIME_BITS{1'b0}}, manual_limit_ms_reg};

    assign link_expired = since_link_w[CMP_W-1:0] > link_ms_w[CMP_W-1:0];
    assign hold_done = since_switch_w[CMP_W-1:0] >= hold_ms_w[CMP_W-1:0];
    assign manual_over = since_manual_w[CMP_W-1:0] >= manual_ms_w[CMP_W-1:0];
    assign saved_mode = saved_auto_reg ? hrs_pkg::MODE_ACTIVE : hrs_pkg::MODE_OFF;

    always_comb
    begin
        cause = hrs_pkg::REASON_NONE;
        if (s1_inv_valid_reg && (s1_power_reg > max_power_reg))
        begin
            cause = hrs_pkg::REASON_POWER;
        end
        else if (s1_inv_valid_reg && (s1_discharge_reg > max_discharge_reg))
        begin
            cause = hrs_pkg::REASON_BATTERY;
        end
        else if (s1_inv_valid_reg && (s1_pv_reg != 16'd0) && (s1_pv_reg < min_pv_reg))
        begin
            cause = hrs_pkg::REASON_PV;
        end
        else if (s1_sunset_reg)
        begin
            cause = hrs_pkg::REASON_SUNSET;
        end
    end

    assign ovr = (cause != hrs_pkg::REASON_NONE);

    always_comb
    begin
        mode_next = mode_reg;
        relay_next = relay_reg;
        reason_next = reason_reg;
        safety_next = safety_reg;
        last_switch_next = last_switch_reg;
        manual_start_next = manual_start_reg;
        saved_auto_next = saved_auto_reg;
        last_link_next = last_link_reg;

        case (s1_action_reg)
            hrs_pkg::ACT_EVALUATE:
            begin
                if (link_expired)
                begin
                    if (!safety_reg)
                    begin
                        relay_next = 1'b0;
                        mode_next = hrs_pkg::MODE_OFF;
                        reason_next = hrs_pkg::REASON_SAFETY;
                        safety_next = 1'b1;
                    end
                end
                else
                begin
                    safety_next = 1'b0;
                    unique case (mode_reg)
                        hrs_pkg::MODE_OFF:
                        begin
                            if (s1_enabled_reg && !ovr && hold_done)
                            begin
                                relay_next = 1'b1;
                                if (!relay_reg)
                                begin
                                    last_switch_next = s1_now_reg;
                                end
                                mode_next = hrs_pkg::MODE_ACTIVE;
                                reason_next = hrs_pkg::REASON_CMD_ON;
                            end
                            else if (s1_enabled_reg && ovr)
                            begin
                                reason_next = cause;
                            end
                            else if (s1_enabled_reg && !hold_done)
                            begin
                                reason_next = hrs_pkg::REASON_CMD_ON;
                            end
                            else
                            begin
                                reason_next = hrs_pkg::REASON_CMD_OFF;
                            end
                        end
                        hrs_pkg::MODE_ACTIVE:
                        begin
                            if ((!s1_enabled_reg && hold_done) || ovr)
                            begin
                                relay_next = 1'b0;
                                if (relay_reg)
                                begin
                                    last_switch_next = s1_now_reg;
                                end
                                mode_next = hrs_pkg::MODE_OFF;
                                reason_next = (!s1_enabled_reg && hold_done) ?
                                              hrs_pkg::REASON_CMD_OFF : cause;
                            end
                        end
                        hrs_pkg::MODE_MAN_ON:
                        begin
                            if (manual_over || (ovr && hold_done))
                            begin
                                relay_next = 1'b0;
                                if (relay_reg)
                                begin
                                    last_switch_next = s1_now_reg;
                                end
                                mode_next = manual_over ? saved_mode : hrs_pkg::MODE_MAN_OFF;
                                reason_next = manual_over ? hrs_pkg::REASON_CMD_OFF : cause;
                            end
                        end
                        hrs_pkg::MODE_MAN_OFF:
                        begin
                            if (manual_over)
                            begin
                                mode_next = saved_mode;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hrs_pkg::ACT_BUTTON:
            begin
                unique case (mode_reg) inside
                    hrs_pkg::MODE_OFF, hrs_pkg::MODE_ACTIVE:
                    begin
                        saved_auto_next = (mode_reg == hrs_pkg::MODE_ACTIVE);
                        manual_start_next = s1_now_reg;
                        relay_next = !relay_reg;
                        last_switch_next = s1_now_reg;
                        mode_next = relay_reg ? hrs_pkg::MODE_MAN_OFF : hrs_pkg::MODE_MAN_ON;
                        reason_next = hrs_pkg::REASON_BUTTON;
                    end
                    hrs_pkg::MODE_MAN_ON:
                    begin
                        relay_next = 1'b0;
                        if (relay_reg)
                        begin
                            last_switch_next = s1_now_reg;
                        end
                        mode_next = saved_mode;
                        reason_next = hrs_pkg::REASON_CMD_OFF;
                    end
                    hrs_pkg::MODE_MAN_OFF:
                    begin
                        mode_next = saved_mode;
                    end
                    default: ;
                endcase
            end
            hrs_pkg::ACT_LINK:
            begin
                last_link_next = s1_now_reg;
            end
            default:
            begin
                relay_next = 1'b0;
                mode_next = hrs_pkg::MODE_OFF;
                reason_next = hrs_pkg::REASON_SAFETY;
                safety_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hrs_pkg::MODE_OFF;
            relay_reg <= 1'b0;
            reason_reg <= hrs_pkg::REASON_NONE;
            safety_reg <= 1'b0;
            last_switch_reg <= '0;
            manual_start_reg <= '0;
            saved_auto_reg <= 1'b0;
            last_link_reg <= '0;
        end
        else if (s1_fire)
        begin
            mode_reg <= mode_next;
            relay_reg <= relay_next;
            reason_reg <= reason_next;
            safety_reg <= safety_next;
            last_switch_reg <= last_switch_next;
            manual_start_reg <= manual_start_next;
            saved_auto_reg <= saved_auto_next;
            last_link_reg <= last_link_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_relay_reg <= relay_next;
            out_reason_reg <= reason_next;
            out_mode_reg <= hrs_pkg::mode_code(mode_next);
            out_safety_reg <= safety_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign relay_on = out_relay_reg;
    assign reason = out_reason_reg;
    assign mode = out_mode_reg;
    assign safety_active = out_safety_reg;

endmodule

### design/hrs_checker.sv
// ---------------------------------------------------------------------------
// Heating relay supervisor checker
// Port-level assertions on the supervisor core, attached by a bind statement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic       relay_on,
    input logic [3:0] reason,
    input logic [1:0] mode
);

    `HRS_ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |=> !result_valid, "result during reset")

    `HRS_ASSERT(a_result_hold, clk, rst_n,
        result_valid && result_stall |=> result_valid && $stable(relay_on)
            && $stable(reason) && $stable(mode),
        "stalled result changed")

    `HRS_ASSERT(a_stall_cause, clk, rst_n,
        item_stall |-> result_valid && result_stall,
        "item stalled without a stalled result")

    `HRS_ASSERT(a_manual_on_relay, clk, rst_n,
        result_valid && (mode == hrs_pkg::MODE_CODE_MAN_ON) |-> relay_on,
        "manual on with relay off")

    `HRS_ASSERT(a_manual_off_relay, clk, rst_n,
        result_valid && (mode == hrs_pkg::MODE_CODE_MAN_OFF) |-> !relay_on,
        "manual off with relay on")

endmodule

bind heating_relay_supervisor_core hrs_checker u_hrs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .relay_on(relay_on),
    .reason(reason),
    .mode(mode)
);

### test/hrs_checker.sv
// ---------------------------------------------------------------------------
// Heating relay supervisor checker
// Watches the configuration port and both channels of the supervisor core,
// keeps its own copy of the supervisor state, predicts the status for every
// accepted item and compares each accepted result against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrs_scoreboard
    import hrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic [1:0]             action,
    input  logic [31:0]            now_ms,
    input  logic                   heating_enabled,
    input  logic                   inverter_valid,
    input  logic [15:0]            apparent_power,
    input  logic [15:0]            discharge_current,
    input  logic [15:0]            pv_voltage,
    input  logic                   sunset_active,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   relay_on,
    input  logic [3:0]             reason,
    input  logic [1:0]             mode,
    input  logic                   safety_active,
    output int                     fail_count,
    output int                     outstanding,
    output int                     checked
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        action_t     act;
        logic [31:0] now;
        logic        en;
        logic        inv;
        logic [15:0] pwr;
        logic [15:0] dis;
        logic [15:0] pv;
        logic        sun;
    } supply_item_t;

    typedef struct packed {
        logic       relay;
        logic [3:0] why;
        logic [1:0] md;
        logic       latched;
    } relay_status_t;

    logic [15:0] lim_power;
    logic [15:0] lim_discharge;
    logic [15:0] lim_pv;
    logic [15:0] link_limit_s;
    logic [15:0] hold_on_s;
    logic [15:0] hold_off_s;
    logic [15:0] manual_limit_s;

    logic [1:0]  sup_mode;
    logic        sup_relay;
    logic [3:0]  sup_reason;
    logic        sup_latch;
    logic [31:0] switched_at;
    logic [31:0] manual_at;
    logic        saved_active;
    logic [31:0] link_at;

    relay_status_t status_queue[$];
    int mismatches;
    int compared;

    function automatic logic [31:0] secs_ms(input logic [15:0] secs);
        return {16'd0, secs} * 32'd1000;
    endfunction

    function automatic logic [31:0] elapsed(input logic [31:0] later, input logic [31:0] earlier);
        return later - earlier;
    endfunction

    function automatic logic hold_met(input logic [31:0] now);
        return elapsed(now, switched_at) >= secs_ms(sup_relay ? hold_on_s : hold_off_s);
    endfunction

    function automatic logic [3:0] limit_cause(input supply_item_t it);
        if (it.inv)
        begin
            if (it.pwr > lim_power)
                return REASON_POWER;
            if (it.dis > lim_discharge)
                return REASON_BATTERY;
            if (it.pv != 16'd0 && it.pv < lim_pv)
                return REASON_PV;
        end
        if (it.sun)
            return REASON_SUNSET;
        return REASON_NONE;
    endfunction

    function automatic logic [1:0] restored_mode();
        return saved_active ? MODE_CODE_ACTIVE : MODE_CODE_OFF;
    endfunction

    task automatic reset_model();
        lim_power = MAX_POWER_RST;
        lim_discharge = MAX_DISCHARGE_RST;
        lim_pv = MIN_PV_VOLTAGE_RST;
        link_limit_s = LINK_TIMEOUT_S_RST;
        hold_on_s = HOLD_ON_S_RST;
        hold_off_s = HOLD_OFF_S_RST;
        manual_limit_s = MANUAL_LIMIT_S_RST;
        sup_mode = MODE_CODE_OFF;
        sup_relay = 1'b0;
        sup_reason = REASON_NONE;
        sup_latch = 1'b0;
        switched_at = 32'd0;
        manual_at = 32'd0;
        saved_active = 1'b0;
        link_at = 32'd0;
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_MAX_POWER: lim_power = val;
            CFG_MAX_DISCHARGE: lim_discharge = val;
            CFG_MIN_PV_VOLTAGE: lim_pv = val;
            CFG_LINK_TIMEOUT: link_limit_s = val;
            CFG_HOLD_ON: hold_on_s = val;
            CFG_HOLD_OFF: hold_off_s = val;
            CFG_MANUAL_LIMIT: manual_limit_s = val;
            default: ;
        endcase
    endtask

    task automatic drive_relay(input logic on, input logic [31:0] now);
        if (sup_relay != on)
        begin
            sup_relay = on;
            switched_at = now;
        end
    endtask

    task automatic trip_safety();
        sup_relay = 1'b0;
        sup_mode = MODE_CODE_OFF;
        sup_reason = REASON_SAFETY;
        sup_latch = 1'b1;
    endtask

    task automatic evaluate_rules(input supply_item_t it);
        logic [3:0] cause;
        logic       ovr;
        logic       manual_over;
        cause = limit_cause(it);
        ovr = cause != REASON_NONE;
        manual_over = elapsed(it.now, manual_at) >= secs_ms(manual_limit_s);
        if (elapsed(it.now, link_at) > secs_ms(link_limit_s))
        begin
            if (!sup_latch)
                trip_safety();
            return;
        end
        sup_latch = 1'b0;
        case (sup_mode)
            MODE_CODE_OFF:
            begin
                if (it.en && !ovr && hold_met(it.now))
                begin
                    drive_relay(1'b1, it.now);
                    sup_mode = MODE_CODE_ACTIVE;
                    sup_reason = REASON_CMD_ON;
                end
                else if (it.en && ovr)
                    sup_reason = cause;
                else if (it.en && !hold_met(it.now))
                    sup_reason = REASON_CMD_ON;
                else
                    sup_reason = REASON_CMD_OFF;
            end
            MODE_CODE_ACTIVE:
            begin
                if (!it.en && hold_met(it.now))
                begin
                    drive_relay(1'b0, it.now);
                    sup_mode = MODE_CODE_OFF;
                    sup_reason = REASON_CMD_OFF;
                end
                else if (ovr)
                begin
                    drive_relay(1'b0, it.now);
                    sup_mode = MODE_CODE_OFF;
                    sup_reason = cause;
                end
            end
            MODE_CODE_MAN_ON:
            begin
                if (manual_over)
                begin
                    drive_relay(1'b0, it.now);
                    sup_mode = restored_mode();
                    sup_reason = REASON_CMD_OFF;
                end
                else if (ovr && hold_met(it.now))
                begin
                    drive_relay(1'b0, it.now);
                    sup_mode = MODE_CODE_MAN_OFF;
                    sup_reason = cause;
                end
            end
            default:
            begin
                if (manual_over)
                    sup_mode = restored_mode();
            end
        endcase
    endtask

    task automatic press_button(input logic [31:0] now);
        case (sup_mode) inside
            MODE_CODE_OFF, MODE_CODE_ACTIVE:
            begin
                saved_active = sup_mode == MODE_CODE_ACTIVE;
                manual_at = now;
                if (sup_relay)
                begin
                    drive_relay(1'b0, now);
                    sup_mode = MODE_CODE_MAN_OFF;
                end
                else
                begin
                    drive_relay(1'b1, now);
                    sup_mode = MODE_CODE_MAN_ON;
                end
                sup_reason = REASON_BUTTON;
            end
            MODE_CODE_MAN_ON:
            begin
                drive_relay(1'b0, now);
                sup_mode = restored_mode();
                sup_reason = REASON_CMD_OFF;
            end
            default: sup_mode = restored_mode();
        endcase
    endtask

    task automatic advance_supervisor(input supply_item_t it, output relay_status_t st);
        case (it.act)
            ACT_EVALUATE: evaluate_rules(it);
            ACT_BUTTON: press_button(it.now);
            ACT_LINK: link_at = it.now;
            default: trip_safety();
        endcase
        st.relay = sup_relay;
        st.why = sup_reason;
        st.md = sup_mode;
        st.latched = sup_latch;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        relay_status_t got;
        relay_status_t want;
        supply_item_t  it;
        if (!rst_n)
        begin
            reset_model();
            status_queue.delete();
            mismatches = 0;
            compared = 0;
            fail_count <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got.relay = relay_on;
                got.why = reason;
                got.md = mode;
                got.latched = safety_active;
                if (status_queue.size() == 0)
                begin
                    if (mismatches < PRINT_LIMIT)
                        $display("%0t ns: result transfer with no status expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = status_queue.pop_front();
                    if (want.relay !== got.relay)
                        report_field("relay_on", want.relay, got.relay);
                    if (want.why !== got.why)
                        report_field("reason", want.why, got.why);
                    if (want.md !== got.md)
                        report_field("mode", want.md, got.md);
                    if (want.latched !== got.latched)
                        report_field("safety_active", want.latched, got.latched);
                    compared++;
                end
            end
            if (cfg_we)
                write_limit(cfg_index, cfg_data);
            if (item_valid && !item_stall)
            begin
                it.act = action_t'(action);
                it.now = now_ms;
                it.en = heating_enabled;
                it.inv = inverter_valid;
                it.pwr = apparent_power;
                it.dis = discharge_current;
                it.pv = pv_voltage;
                it.sun = sunset_active;
                advance_supervisor(it, want);
                status_queue.push_back(want);
            end
            fail_count <= mismatches;
            outstanding <= status_queue.size();
            checked <= compared;
        end
    end

endmodule

### test/testbench.sv
// ---------------------------------------------------------------------------
// Heating relay supervisor testbench
// Drives a short directed sequence through every action and special case, then
// random traffic over several register settings, including all-zero and
// all-ones limits, with bursty input transfers and random result stalls. The
// checker beside the core predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import hrs_pkg::*;

    localparam int NUM_REGS = 7;
    localparam int NUM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NO_GAP_PHASE = 4;
    localparam int DRAIN_PHASE = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic [1:0]             action = ACT_EVALUATE;
    logic [31:0]            now_ms = 32'd0;
    logic                   heating_enabled = 1'b0;
    logic                   inverter_valid = 1'b0;
    logic [15:0]            apparent_power = 16'd0;
    logic [15:0]            discharge_current = 16'd0;
    logic [15:0]            pv_voltage = 16'd0;
    logic                   sunset_active = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   relay_on;
    logic [3:0]             reason;
    logic [1:0]             mode;
    logic                   safety_active;

    int          fail_count;
    int          outstanding;
    int          checked;
    int          action_count[4] = '{0, 0, 0, 0};
    logic [15:0] plan[NUM_REGS];
    logic [31:0] clock_ms = 32'd0;
    int          stall_pct = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    heating_relay_supervisor_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .action(action),
        .now_ms(now_ms),
        .heating_enabled(heating_enabled),
        .inverter_valid(inverter_valid),
        .apparent_power(apparent_power),
        .discharge_current(discharge_current),
        .pv_voltage(pv_voltage),
        .sunset_active(sunset_active),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .relay_on(relay_on),
        .reason(reason),
        .mode(mode),
        .safety_active(safety_active)
    );

    hrs_scoreboard u_scoreboard (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .action(action),
        .now_ms(now_ms),
        .heating_enabled(heating_enabled),
        .inverter_valid(inverter_valid),
        .apparent_power(apparent_power),
        .discharge_current(discharge_current),
        .pv_voltage(pv_voltage),
        .sunset_active(sunset_active),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .relay_on(relay_on),
        .reason(reason),
        .mode(mode),
        .safety_active(safety_active),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .checked(checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_pct = 0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 4)) inside
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_left = $urandom_range(20, 300);
            end
            stall_left--;
            result_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles at %0t ns", WATCHDOG_LIMIT, $time);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input action_t act, input logic [31:0] t, input logic en,
                             input logic inv, input logic [15:0] pwr, input logic [15:0] dis,
                             input logic [15:0] pv, input logic sun);
        item_valid <= 1'b1;
        action <= act;
        now_ms <= t;
        heating_enabled <= en;
        inverter_valid <= inv;
        apparent_power <= pwr;
        discharge_current <= dis;
        pv_voltage <= pv;
        sunset_active <= sun;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        action_count[act]++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_plan();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= plan[i];
            @(posedge clk);
        end
        cfg_index <= CFG_UNUSED;
        cfg_data <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic make_plan(input int phase);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (phase == 1)
                plan[i] = 16'd0;
            else if (phase == 2)
                plan[i] = 16'hFFFF;
            else if (i < CFG_LINK_TIMEOUT)
                plan[i] = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
            else
                plan[i] = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        end
    endtask

    function automatic logic [15:0] sensor_level(input logic [15:0] thr, input logic calm,
                                                 input logic is_pv);
        int off;
        int v;
        if (calm)
        begin
            if (!is_pv)
                return 16'($urandom_range(0, thr));
            if ($urandom_range(0, 1) == 0)
                return 16'd0;
            return 16'($urandom_range(thr, 16'hFFFF));
        end
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1:
            begin
                off = $urandom_range(0, 6);
                v = int'(thr) + off - 3;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return 16'(v);
            end
            2: return 16'd0;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic send_random(input int unsigned step_max);
        int      r;
        logic    calm;
        action_t act;
        r = $urandom_range(0, 99);
        if (r < 50)
            act = ACT_EVALUATE;
        else if (r < 78)
            act = ACT_LINK;
        else if (r < 94)
            act = ACT_BUTTON;
        else
            act = ACT_EMERGENCY;
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else if ($urandom_range(0, 3) != 0)
            clock_ms = clock_ms + $urandom_range(0, step_max);
        calm = $urandom_range(0, 99) < 60;
        send_item(act, clock_ms, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                  sensor_level(plan[CFG_MAX_POWER], calm, 1'b0),
                  sensor_level(plan[CFG_MAX_DISCHARGE], calm, 1'b0),
                  sensor_level(plan[CFG_MIN_PV_VOLTAGE], calm, 1'b1),
                  calm ? 1'b0 : $urandom_range(0, 3) == 0);
    endtask

    task automatic run_directed();
        send_item(ACT_EVALUATE, 32'd0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_LINK, 32'd1000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd61000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd62000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd62500, 1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd63000, 1'b1, 1'b1, 16'd0, 16'hFFFF, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd63500, 1'b1, 1'b1, 16'd0, 16'd0, 16'd1, 1'b0);
        send_item(ACT_EVALUATE, 32'd64000, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
        send_item(ACT_EVALUATE, 32'd64500, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(ACT_EVALUATE, 32'd65000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_BUTTON, 32'd66000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_BUTTON, 32'd67000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_BUTTON, 32'd130000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd131000, 1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd191000, 1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_item(ACT_BUTTON, 32'd192000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EMERGENCY, 32'd193000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_EVALUATE, 32'd194000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd400000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd401000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_LINK, 32'hFFFF_FF00, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'h0000_0100, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_BUTTON, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_LINK, 32'd3600100, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(ACT_EVALUATE, 32'd3601000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    initial
    begin
        int unsigned longest;
        int unsigned step_max;
        int          burst_left;
        int          gap;
        plan[CFG_MAX_POWER] = MAX_POWER_RST;
        plan[CFG_MAX_DISCHARGE] = MAX_DISCHARGE_RST;
        plan[CFG_MIN_PV_VOLTAGE] = MIN_PV_VOLTAGE_RST;
        plan[CFG_LINK_TIMEOUT] = LINK_TIMEOUT_S_RST;
        plan[CFG_HOLD_ON] = HOLD_ON_S_RST;
        plan[CFG_HOLD_OFF] = HOLD_OFF_S_RST;
        plan[CFG_MANUAL_LIMIT] = MANUAL_LIMIT_S_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        burst_left = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                make_plan(phase);
                load_plan();
            end
            longest = 0;
            for (int i = CFG_LINK_TIMEOUT; i < NUM_REGS; i++)
                if (plan[i] > longest)
                    longest = plan[i];
            step_max = longest * 250 + 500;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0 && phase != NO_GAP_PHASE)
                    begin
                        item_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                if (phase == DRAIN_PHASE && k == ITEMS_PER_PHASE / 2)
                    drain();
                send_random(step_max);
            end
            drain();
        end
        repeat (8) @(posedge clk);
        $display("Covered %0d evaluate, %0d button, %0d link and %0d emergency transfers",
                 action_count[ACT_EVALUATE], action_count[ACT_BUTTON],
                 action_count[ACT_LINK], action_count[ACT_EMERGENCY]);
        $display("over %0d register settings; %0d results compared, %0d mismatches.",
                 NUM_PHASES, checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
